// ===== rtl/core/stbrchk_pkg.sv =====
// ----------------------------------------------------------------------------
// stbrchk_pkg
// Shared types and constants of the style text brace checker.
// ----------------------------------------------------------------------------
package stbrchk_pkg;

   // Character codes of interest
   localparam logic [15:0] CH_NL    = 16'h000A;
   localparam logic [15:0] CH_DQ    = 16'h0022;
   localparam logic [15:0] CH_SQ    = 16'h0027;
   localparam logic [15:0] CH_STAR  = 16'h002A;
   localparam logic [15:0] CH_SLASH = 16'h002F;
   localparam logic [15:0] CH_BSL   = 16'h005C;
   localparam logic [15:0] CH_OPEN  = 16'h007B;
   localparam logic [15:0] CH_CLOSE = 16'h007D;

   localparam int CHAR_W   = 16;
   localparam int STATUS_W = 3;
   localparam int LINE_W   = 20;

   localparam int LINE_BITS_DEFAULT   = 20;
   localparam int DEPTH_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [3:0] {
      TOK_OTHER,
      TOK_NL,
      TOK_DQ,
      TOK_SQ,
      TOK_STAR,
      TOK_SLASH,
      TOK_BSL,
      TOK_OPEN,
      TOK_CLOSE
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic         last;
   } tok_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_CLOSE      = 3'd1,
      ST_COMMENT    = 3'd2,
      ST_STRING     = 3'd3,
      ST_OPEN       = 3'd4
   } status_type;

   // Handshake between the queue and the back end
   typedef struct packed {
      logic    empty;
      tok_type data;
   } queue_head_type;

   function automatic tok_kind_type classify(input logic [CHAR_W-1:0] c);
      tok_kind_type k;
      case (c)
         CH_NL:    k = TOK_NL;
         CH_DQ:    k = TOK_DQ;
         CH_SQ:    k = TOK_SQ;
         CH_STAR:  k = TOK_STAR;
         CH_SLASH: k = TOK_SLASH;
         CH_BSL:   k = TOK_BSL;
         CH_OPEN:  k = TOK_OPEN;
         CH_CLOSE: k = TOK_CLOSE;
         default:  k = TOK_OTHER;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/stbrchk_front.sv =====
// ----------------------------------------------------------------------------
// stbrchk_front
// Accepts code units, classifies them into tokens and hands them to the queue.
// ----------------------------------------------------------------------------
module stbrchk_front
   import stbrchk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              req_last_char,
   output logic              req_full,
   output logic              tok_push,
   output tok_type           tok_data,
   input  logic              tok_full
);

   logic    valid_ff, valid_in;
   tok_type tok_ff, tok_in;
   logic    load;

   assign req_full = valid_ff && tok_full;
   assign load     = req_push && !req_full;
   assign tok_push = valid_ff;
   assign tok_data = tok_ff;

   always_comb begin
      valid_in = valid_ff;
      tok_in   = tok_ff;
      if (load) begin
         valid_in    = 1'b1;
         tok_in.kind = classify(req_char_code);
         tok_in.last = req_last_char;
      end else if (valid_ff && !tok_full) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tok_ff <= tok_in;
   end

endmodule

// ===== rtl/core/stbrchk_queue.sv =====
// ----------------------------------------------------------------------------
// stbrchk_queue
// Short token queue between the classifier and the scanner.
// ----------------------------------------------------------------------------
module stbrchk_queue
   import stbrchk_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tok_type        push_data,
   output logic           full,
   input  logic           pop,
   output queue_head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   tok_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.empty = (count_ff == '0);
   assign head.data  = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !head.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/stbrchk_back.sv =====
// ----------------------------------------------------------------------------
// stbrchk_back
// Scanner: applies one token per cycle (final ones may stall), issues results.
// ----------------------------------------------------------------------------
module stbrchk_back
   import stbrchk_pkg::*;
#(
   parameter int LINE_BITS  = LINE_BITS_DEFAULT,
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  queue_head_type      head,
   output logic                tok_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [LINE_W-1:0]   rsp_line_number
);

   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

   logic [LINE_BITS-1:0]  line_count_ff, line_count_in;
   logic [DEPTH_BITS-1:0] brace_depth_ff, brace_depth_in;
   logic [LINE_BITS-1:0]  first_open_line_ff, first_open_line_in;
   logic [LINE_BITS-1:0]  comment_open_line_ff, comment_open_line_in;
   logic [LINE_BITS-1:0]  close_error_line_ff, close_error_line_in;
   logic in_comment_ff, in_comment_in;
   logic in_string_ff, in_string_in;
   logic quote_single_ff, quote_single_in;
   logic slash_pending_ff, slash_pending_in;
   logic star_pending_ff, star_pending_in;
   logic escape_pending_ff, escape_pending_in;
   logic close_error_ff, close_error_in;

   logic                rsp_valid_ff;
   status_type          status_ff, status_in;
   logic [LINE_W-1:0]   line_ff;
   logic [LINE_BITS-1:0] sel_line;
   logic [LINE_BITS+LINE_W-1:0] line_ext;

   tok_kind_type kind;
   logic         quote_match;
   logic         opened_comment;

   assign kind      = head.data.kind;
   // only a final token has to wait for the result register to drain
   assign tok_pop   = !head.empty && (!head.data.last || !rsp_valid_ff || rsp_pop);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_line_number = line_ff;
   assign quote_match = quote_single_ff ? (kind == TOK_SQ) : (kind == TOK_DQ);

   always_comb begin
      line_count_in        = line_count_ff;
      brace_depth_in       = brace_depth_ff;
      first_open_line_in   = first_open_line_ff;
      comment_open_line_in = comment_open_line_ff;
      close_error_line_in  = close_error_line_ff;
      in_comment_in        = in_comment_ff;
      in_string_in         = in_string_ff;
      quote_single_in      = quote_single_ff;
      slash_pending_in     = slash_pending_ff;
      star_pending_in      = star_pending_ff;
      escape_pending_in    = escape_pending_ff;
      close_error_in       = close_error_ff;
      opened_comment       = 1'b0;

      if (escape_pending_ff) begin
         escape_pending_in = 1'b0;
      end else if (kind == TOK_NL) begin
         if (line_count_ff != '1) begin
            line_count_in = line_count_ff + LINE_ONE;
         end
         slash_pending_in = 1'b0;
         star_pending_in  = 1'b0;
      end else if (in_comment_ff) begin
         if (star_pending_ff && kind == TOK_SLASH) begin
            in_comment_in   = 1'b0;
            star_pending_in = 1'b0;
         end else begin
            star_pending_in = (kind == TOK_STAR);
         end
      end else if (in_string_ff) begin
         if (kind == TOK_BSL) begin
            escape_pending_in = 1'b1;
         end else if (quote_match) begin
            in_string_in = 1'b0;
         end
      end else begin
         if (slash_pending_ff) begin
            slash_pending_in = 1'b0;
            if (kind == TOK_STAR) begin
               opened_comment       = 1'b1;
               in_comment_in        = 1'b1;
               star_pending_in      = 1'b0;
               comment_open_line_in = line_count_ff;
            end
         end
         if (!opened_comment) begin
            case (kind)
               TOK_SLASH: begin
                  slash_pending_in = 1'b1;
               end
               TOK_DQ, TOK_SQ: begin
                  in_string_in    = 1'b1;
                  quote_single_in = (kind == TOK_SQ);
               end
               TOK_OPEN: begin
                  if (brace_depth_ff == '0) begin
                     first_open_line_in = line_count_ff;
                  end
                  if (brace_depth_ff != '1) begin
                     brace_depth_in = brace_depth_ff + DEPTH_BITS'(1);
                  end
               end
               TOK_CLOSE: begin
                  if (brace_depth_ff == '0) begin
                     if (!close_error_ff) begin
                        close_error_in      = 1'b1;
                        close_error_line_in = line_count_ff;
                     end
                  end else begin
                     brace_depth_in = brace_depth_ff - DEPTH_BITS'(1);
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // Final status, by priority
      if (close_error_in) begin
         status_in = ST_CLOSE;
         sel_line  = close_error_line_in;
      end else if (in_comment_in) begin
         status_in = ST_COMMENT;
         sel_line  = comment_open_line_in;
      end else if (in_string_in) begin
         status_in = ST_STRING;
         sel_line  = line_count_in;
      end else if (brace_depth_in != '0) begin
         status_in = ST_OPEN;
         sel_line  = first_open_line_in;
      end else begin
         status_in = ST_OK;
         sel_line  = '0;
      end
      line_ext = {LINE_W'(0), sel_line};
   end

   always_ff @(posedge clock) begin
      if (reset || (tok_pop && head.data.last)) begin
         line_count_ff        <= LINE_ONE;
         brace_depth_ff       <= '0;
         first_open_line_ff   <= '0;
         comment_open_line_ff <= '0;
         close_error_line_ff  <= '0;
         in_comment_ff        <= 1'b0;
         in_string_ff         <= 1'b0;
         quote_single_ff      <= 1'b0;
         slash_pending_ff     <= 1'b0;
         star_pending_ff      <= 1'b0;
         escape_pending_ff    <= 1'b0;
         close_error_ff       <= 1'b0;
      end else if (tok_pop) begin
         line_count_ff        <= line_count_in;
         brace_depth_ff       <= brace_depth_in;
         first_open_line_ff   <= first_open_line_in;
         comment_open_line_ff <= comment_open_line_in;
         close_error_line_ff  <= close_error_line_in;
         in_comment_ff        <= in_comment_in;
         in_string_ff         <= in_string_in;
         quote_single_ff      <= quote_single_in;
         slash_pending_ff     <= slash_pending_in;
         star_pending_ff      <= star_pending_in;
         escape_pending_ff    <= escape_pending_in;
         close_error_ff       <= close_error_in;
      end

      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tok_pop && head.data.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end

      if (tok_pop && head.data.last) begin
         status_ff <= status_in;
         line_ff   <= line_ext[LINE_W-1:0];
      end
   end

endmodule

// ===== rtl/core/style_text_brace_checker.sv =====
// A result reaches the rsp_ ports from the final code unit of a text through the
// front-end token register, the token queue and the result register.
// Throughput: one code unit per cycle while req_full is low, set by the scanner update.
// Reset: synchronous, active high; clears the queue and returns the scanner to
// the start of a new text (line one, depth zero, no modes pending).
// ----------------------------------------------------------------------------
// style_text_brace_checker
// Streams style text code units and reports brace, comment and string errors.
// ----------------------------------------------------------------------------
module style_text_brace_checker
   import stbrchk_pkg::*;
#(
   parameter int LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int DEPTH_BITS  = DEPTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   // input transaction: one code unit
   input  logic                req_push,
   output logic                req_full,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic                req_last_char,
   // result transaction: one status per text
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [LINE_W-1:0]   rsp_line_number
);

   // Classified token leaving the front end
   logic           tok_push;
   tok_type        tok_data;
   logic           tok_full;
   // Oldest token waiting for the scanner
   queue_head_type head;
   logic           tok_pop;

   // Front end: take a code unit, classify it, hold it until the queue has room
   stbrchk_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .req_full      (req_full),
      .tok_push      (tok_push),
      .tok_data      (tok_data),
      .tok_full      (tok_full)
   );

   // Decouple the classifier from the scanner so that each can stall alone
   stbrchk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_push),
      .push_data (tok_data),
      .full      (tok_full),
      .pop       (tok_pop),
      .head      (head)
   );

   // Back end: advance the text state one token per cycle, a final token once the result register is free;
   // on the final token latch the status into the result register and restart for the next text
   stbrchk_back #(
      .LINE_BITS  (LINE_BITS),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .tok_pop         (tok_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_status      (rsp_status),
      .rsp_line_number (rsp_line_number)
   );

endmodule
